// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define BPT_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Check that also holds during reset.
`define BPT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) else $error("assertion failed");

`endif

// ===== sv/bpt_pkg.sv =====
// Shared codes and state type for the B+-tree key index.
`default_nettype none
package bpt_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_NO_NODES  = 3'd3;
    localparam logic [2:0] ST_TOO_DEEP  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DESC,
        S_CNT,
        S_MRG,
        S_WL,
        S_WR,
        S_URD,
        S_ROOT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== sv/bpt_node_mem.sv =====
// Node pool memory: one row per node, registered read, fill-count masking.
`default_nettype none
module bpt_node_mem #(
    parameter int NODES  = 1024,
    parameter int ROW_W  = 424,
    parameter int META_W = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_we,
    input  wire logic [$clog2(NODES)-1:0]  i_waddr,
    input  wire logic [ROW_W-1:0]          i_wdata,
    input  wire logic                      i_re,
    input  wire logic [$clog2(NODES)-1:0]  i_raddr,
    input  wire logic [$clog2(NODES):0]    i_fill,
    output logic      [ROW_W-1:0]          o_rdata,
    output logic      [$clog2(NODES)-1:0]  o_ridx
);
    localparam int NB = $clog2(NODES);

    logic [ROW_W-1:0] mem [NODES];
    logic [ROW_W-1:0] r_rdata;
    logic [NB-1:0]    r_ridx;
    logic             r_n0;
    logic             unwritten;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
            r_ridx  <= i_raddr;
        end
    end

    // Node 0 is the empty root leaf until first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n0 <= 1'b0;
        end else if (i_we && i_waddr == '0) begin
            r_n0 <= 1'b1;
        end
    end

    // Rows at or past the allocation point read with zero count and level.
    assign unwritten = ({1'b0, r_ridx} >= i_fill) || (r_ridx == '0 && !r_n0);

    always_comb begin
        o_rdata = r_rdata;
        if (unwritten) begin
            o_rdata[ROW_W-1 -: META_W] = '0;
        end
    end

    assign o_ridx = r_ridx;
endmodule
`default_nettype wire

// ===== sv/bpt_merge.sv =====
// Node merge: opens a key lane and a slot lane and drops a new entry in.
`default_nettype none
module bpt_merge #(
    parameter int MAX_KEYS = 4,
    parameter int SW       = 32
) (
    input  wire logic [MAX_KEYS-1:0][63:0]         i_keys,
    input  wire logic [MAX_KEYS:0][SW-1:0]         i_slots,
    input  wire logic [$clog2(MAX_KEYS+1)-1:0]     i_kpos,
    input  wire logic                              i_soff,
    input  wire logic [63:0]                       i_ikey,
    input  wire logic [SW-1:0]                     i_islot,
    output logic      [MAX_KEYS:0][63:0]           o_tk,
    output logic      [MAX_KEYS+1:0][SW-1:0]       o_tv
);
    localparam int CW = $clog2(MAX_KEYS+1);

    logic [CW:0] spos;
    assign spos = {1'b0, i_kpos} + (CW+1)'(i_soff);

    for (genvar j = 0; j <= MAX_KEYS; j++) begin : g_key
        if (j == 0) begin : g_first
            assign o_tk[j] = (i_kpos == '0) ? i_ikey : i_keys[j];
        end else if (j == MAX_KEYS) begin : g_last
            assign o_tk[j] = (i_kpos == CW'(j)) ? i_ikey : i_keys[j-1];
        end else begin : g_mid
            assign o_tk[j] = ((CW+1)'(j) < {1'b0, i_kpos}) ? i_keys[j] :
                             (i_kpos == CW'(j)) ? i_ikey : i_keys[j-1];
        end
    end

    for (genvar j = 0; j <= MAX_KEYS+1; j++) begin : g_slot
        if (j == 0) begin : g_first
            assign o_tv[j] = (spos == '0) ? i_islot : i_slots[j];
        end else if (j == MAX_KEYS+1) begin : g_last
            assign o_tv[j] = (spos == (CW+1)'(j)) ? i_islot : i_slots[j-1];
        end else begin : g_mid
            assign o_tv[j] = ((CW+1)'(j) < spos) ? i_slots[j] :
                             (spos == (CW+1)'(j)) ? i_islot : i_slots[j-1];
        end
    end
endmodule
`default_nettype wire

// ===== sv/bplus_tree_key_index.sv =====
// Top level: B+-tree key index controller over a node pool memory.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_command, i_key, i_value
//  out     | output    | o_out_valid / i_out_ready | o_status, o_found_value
//
// One item is in work at a time. A search or delete reads one node row per
// level of the tree from the pool.
// An insert that splits first counts up the full ancestors, then splits the
// leaf, then each full internal level, then places the last separator or
// writes a new root; every row write goes through the one memory write port.
// Reset is synchronous; the pool needs no clearing pass after reset.
// A result waiting in the output register stalls the next finish only.
`default_nettype none
module bplus_tree_key_index #(
    parameter int MAX_KEYS   = 4,
    parameter int MAX_DEPTH  = 16,
    parameter int NODE_COUNT = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [2:0]  o_status,
    output logic      [31:0] o_found_value
);
    localparam int NB      = $clog2(NODE_COUNT);
    localparam int FW      = NB + 1;
    localparam int SW      = (VALUE_BITS > NB) ? VALUE_BITS : NB;
    localparam int CW      = $clog2(MAX_KEYS+1);
    localparam int LW      = $clog2(MAX_DEPTH+1);
    localparam int DW      = $clog2(MAX_DEPTH);
    localparam int DCW     = $clog2(MAX_DEPTH+1);
    localparam int NEEDW   = $clog2(MAX_DEPTH+3);
    localparam int LEAF_L  = (MAX_KEYS + 2) / 2;
    localparam int MID     = (MAX_KEYS + 1) / 2;
    localparam int LEAF_RC = MAX_KEYS + 1 - LEAF_L;
    localparam int INT_RC  = MAX_KEYS - MID;

    typedef struct packed {
        logic [LW-1:0]                level;
        logic [CW-1:0]                count;
        logic [MAX_KEYS-1:0][63:0]    keys;
        logic [MAX_KEYS:0][SW-1:0]    slots;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    bpt_pkg::t_state r_state, n_state;

    logic [1:0]              r_cmd;
    logic [63:0]             r_key;
    logic [SW-1:0]           r_val;
    logic [DCW-1:0]          r_d, n_d;
    logic [DW-1:0]           r_leaf_d, n_leaf_d;
    logic [DCW-1:0]          r_k, n_k;
    logic [NEEDW-1:0]        r_need, n_need;
    logic [CW-1:0]           r_pos, n_pos;
    logic [DW-1:0]           r_lvl, n_lvl;
    logic                    r_isleaf, n_isleaf;
    logic [NB-1:0]           r_node, n_node;
    logic [LW-1:0]           r_lvlv, n_lvlv;
    logic [MAX_KEYS:0][63:0]     r_tk;
    logic [MAX_KEYS+1:0][SW-1:0] r_tv;
    logic                    tv_load;
    logic [63:0]             r_sep, n_sep;
    logic [NB-1:0]           r_right, n_right;
    logic [NB-1:0]           r_root, n_root;
    logic [FW-1:0]           r_free, n_free;
    logic [2:0]              r_status, n_status;
    logic [31:0]             r_found, n_found;
    logic                    r_ovalid;
    logic [2:0]              r_ostatus;
    logic [31:0]             r_ofound;

    logic [NB-1:0]           r_pnode [MAX_DEPTH];
    logic [CW-1:0]           r_ppos  [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]    r_pfull;
    logic                    path_we;

    // memory port
    logic              mem_we, mem_re;
    logic [NB-1:0]     mem_waddr, mem_raddr, mem_ridx;
    t_row              mem_wdata, rd;
    logic [ROW_W-1:0]  mem_rdata;

    // decode of the row under work
    logic [CW-1:0]     ccnt;
    logic [CW-1:0]     route;
    logic              hit;
    logic [CW-1:0]     hit_idx;
    logic [NB-1:0]     child;
    logic [63:0]       child_x;
    logic              is_leaf_row;
    logic              too_deep;
    logic              out_free;
    logic              accept;
    logic              cnt_stop, cnt_grows;
    logic [FW+1:0]     alloc_end;
    logic [CW-1:0]     ipos;
    logic [CW-1:0]     mg_kpos;
    logic              mg_soff;
    logic [63:0]       mg_ikey;
    logic [SW-1:0]     mg_islot;
    logic [MAX_KEYS:0][63:0]     mg_tk;
    logic [MAX_KEYS+1:0][SW-1:0] mg_tv;
    t_row              ins_row, del_row, wl_row, wr_leaf, wr_int, root_row;
    logic [63:0]       val64;
    logic [63:0]       fnd64;

    assign val64 = {32'b0, i_value};

    bpt_node_mem #(
        .NODES  (NODE_COUNT),
        .ROW_W  (ROW_W),
        .META_W (LW + CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .i_fill  (r_free),
        .o_rdata (mem_rdata),
        .o_ridx  (mem_ridx)
    );

    assign rd = t_row'(mem_rdata);

    always_comb begin
        ccnt = (rd.count > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : rd.count;
        route = ccnt;
        for (int i = MAX_KEYS-1; i >= 0; i--) begin
            if (CW'(i) < ccnt && r_key < rd.keys[i]) route = CW'(i);
        end
        hit = 1'b0;
        hit_idx = '0;
        for (int i = MAX_KEYS-1; i >= 0; i--) begin
            if (CW'(i) < ccnt && r_key == rd.keys[i]) begin
                hit = 1'b1;
                hit_idx = CW'(i);
            end
        end
        child_x = 64'(rd.slots[route]);
        child = (child_x >= 64'(NODE_COUNT)) ? '0 : child_x[NB-1:0];
        is_leaf_row = (rd.level == '0);
        too_deep = (r_d == DCW'(MAX_DEPTH));
        fnd64 = 64'(rd.slots[hit_idx][VALUE_BITS-1:0]);
    end

    // internal position clamped to the node's count
    always_comb begin
        ipos = r_ppos[r_lvl];
        if (ipos > ccnt) ipos = ccnt;
    end

    always_comb begin
        if (r_state == bpt_pkg::S_MRG && !r_isleaf) begin
            mg_kpos  = ipos;
            mg_soff  = 1'b1;
            mg_ikey  = r_sep;
            mg_islot = SW'(r_right);
        end else begin
            mg_kpos  = (r_state == bpt_pkg::S_MRG) ? r_pos : route;
            mg_soff  = 1'b0;
            mg_ikey  = r_key;
            mg_islot = r_val;
        end
    end

    bpt_merge #(
        .MAX_KEYS (MAX_KEYS),
        .SW       (SW)
    ) u_merge (
        .i_keys  (rd.keys),
        .i_slots (rd.slots),
        .i_kpos  (mg_kpos),
        .i_soff  (mg_soff),
        .i_ikey  (mg_ikey),
        .i_islot (mg_islot),
        .o_tk    (mg_tk),
        .o_tv    (mg_tv)
    );

    // rows to write back
    always_comb begin
        ins_row.level = rd.level;
        ins_row.count = ccnt + CW'(1);
        for (int i = 0; i < MAX_KEYS; i++) ins_row.keys[i] = mg_tk[i];
        for (int i = 0; i <= MAX_KEYS; i++) ins_row.slots[i] = mg_tv[i];

        del_row = rd;
        del_row.count = ccnt - CW'(1);
        for (int i = 0; i < MAX_KEYS-1; i++) begin
            if (CW'(i) >= hit_idx) begin
                del_row.keys[i]  = rd.keys[i+1];
                del_row.slots[i] = rd.slots[i+1];
            end
        end

        wl_row.level = r_lvlv;
        wl_row.count = r_isleaf ? CW'(LEAF_L) : CW'(MID);
        for (int i = 0; i < MAX_KEYS; i++) wl_row.keys[i] = r_tk[i];
        for (int i = 0; i <= MAX_KEYS; i++) wl_row.slots[i] = r_tv[i];

        root_row.level = LW'(r_leaf_d) + LW'(1);
        root_row.count = CW'(1);
        root_row.keys = '0;
        root_row.keys[0] = r_sep;
        root_row.slots = '0;
        root_row.slots[0] = SW'(r_pnode[0]);
        root_row.slots[1] = SW'(r_right);
    end

    assign wr_leaf.level = '0;
    assign wr_leaf.count = CW'(LEAF_RC);
    assign wr_int.level  = r_lvlv;
    assign wr_int.count  = CW'(INT_RC);
    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_rkey
        if (LEAF_L + i <= MAX_KEYS) begin : g_l
            assign wr_leaf.keys[i] = r_tk[LEAF_L+i];
        end else begin : g_lz
            assign wr_leaf.keys[i] = '0;
        end
        if (MID + 1 + i <= MAX_KEYS) begin : g_n
            assign wr_int.keys[i] = r_tk[MID+1+i];
        end else begin : g_nz
            assign wr_int.keys[i] = '0;
        end
    end
    for (genvar i = 0; i <= MAX_KEYS; i++) begin : g_rslot
        if (LEAF_L + i <= MAX_KEYS + 1) begin : g_l
            assign wr_leaf.slots[i] = r_tv[LEAF_L+i];
        end else begin : g_lz
            assign wr_leaf.slots[i] = '0;
        end
        if (MID + 1 + i <= MAX_KEYS + 1) begin : g_n
            assign wr_int.slots[i] = r_tv[MID+1+i];
        end else begin : g_nz
            assign wr_int.slots[i] = '0;
        end
    end

    // split counting: walk up while ancestors are full
    always_comb begin
        cnt_stop  = (r_k == '0) || !r_pfull[DW'(r_k - DCW'(1))];
        cnt_grows = (r_k == '0);
        alloc_end = (FW+2)'(r_free) + (FW+2)'(r_need) + (FW+2)'(cnt_grows);
    end

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == bpt_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpt_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_command == bpt_pkg::CMD_INSERT || i_command == bpt_pkg::CMD_SEARCH
                        || i_command == bpt_pkg::CMD_DELETE) begin
                        n_state = bpt_pkg::S_DESC;
                    end else begin
                        n_state = bpt_pkg::S_DONE;
                    end
                end
            end
            bpt_pkg::S_DESC: begin
                if (too_deep) begin
                    n_state = bpt_pkg::S_DONE;
                end else if (is_leaf_row) begin
                    if (r_cmd == bpt_pkg::CMD_INSERT && !hit && ccnt == CW'(MAX_KEYS)) begin
                        n_state = bpt_pkg::S_CNT;
                    end else begin
                        n_state = bpt_pkg::S_DONE;
                    end
                end
            end
            bpt_pkg::S_CNT: begin
                if (cnt_stop) begin
                    if (alloc_end > (FW+2)'(NODE_COUNT)) begin
                        n_state = bpt_pkg::S_DONE;
                    end else if (cnt_grows && 32'(r_leaf_d) + 2 > MAX_DEPTH) begin
                        n_state = bpt_pkg::S_DONE;
                    end else begin
                        n_state = bpt_pkg::S_MRG;
                    end
                end
            end
            bpt_pkg::S_MRG: begin
                if (!r_isleaf && ccnt < CW'(MAX_KEYS)) n_state = bpt_pkg::S_DONE;
                else n_state = bpt_pkg::S_WL;
            end
            bpt_pkg::S_WL:   n_state = bpt_pkg::S_WR;
            bpt_pkg::S_WR:   n_state = (r_lvl == '0) ? bpt_pkg::S_ROOT : bpt_pkg::S_URD;
            bpt_pkg::S_URD:  n_state = bpt_pkg::S_MRG;
            bpt_pkg::S_ROOT: n_state = bpt_pkg::S_DONE;
            bpt_pkg::S_DONE: begin
                if (out_free) n_state = bpt_pkg::S_IDLE;
            end
            default: n_state = bpt_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_d = r_d;  n_leaf_d = r_leaf_d;  n_k = r_k;  n_need = r_need;
        n_pos = r_pos;  n_lvl = r_lvl;  n_isleaf = r_isleaf;  n_node = r_node;
        n_lvlv = r_lvlv;  n_sep = r_sep;  n_right = r_right;  n_root = r_root;
        n_free = r_free;  n_status = r_status;  n_found = r_found;
        tv_load = 1'b0;  path_we = 1'b0;
        mem_we = 1'b0;  mem_waddr = r_node;  mem_wdata = wl_row;
        mem_re = 1'b0;  mem_raddr = r_root;
        case (r_state)
            bpt_pkg::S_IDLE: begin
                n_d = '0;
                n_status = bpt_pkg::ST_OK;
                n_found = '0;
                mem_re = accept;
            end
            bpt_pkg::S_DESC: begin
                if (too_deep) begin
                    n_status = bpt_pkg::ST_TOO_DEEP;
                end else if (!is_leaf_row) begin
                    path_we = 1'b1;
                    n_d = r_d + DCW'(1);
                    mem_re = 1'b1;
                    mem_raddr = child;
                end else begin
                    path_we = 1'b1;
                    n_leaf_d = DW'(r_d);
                    n_k = r_d;
                    n_need = NEEDW'(1);
                    n_pos = route;
                    if (r_cmd == bpt_pkg::CMD_INSERT) begin
                        if (hit) begin
                            n_status = bpt_pkg::ST_DUPLICATE;
                        end else if (ccnt < CW'(MAX_KEYS)) begin
                            mem_we = 1'b1;
                            mem_waddr = mem_ridx;
                            mem_wdata = ins_row;
                        end
                    end else if (!hit) begin
                        n_status = bpt_pkg::ST_NOT_FOUND;
                    end else if (r_cmd == bpt_pkg::CMD_SEARCH) begin
                        n_found = fnd64[31:0];
                    end else begin
                        mem_we = 1'b1;
                        mem_waddr = mem_ridx;
                        mem_wdata = del_row;
                    end
                end
            end
            bpt_pkg::S_CNT: begin
                if (!cnt_stop) begin
                    n_k = r_k - DCW'(1);
                    n_need = r_need + NEEDW'(1);
                end else if (alloc_end > (FW+2)'(NODE_COUNT)) begin
                    n_status = bpt_pkg::ST_NO_NODES;
                end else if (cnt_grows && 32'(r_leaf_d) + 2 > MAX_DEPTH) begin
                    n_status = bpt_pkg::ST_TOO_DEEP;
                end else begin
                    n_isleaf = 1'b1;
                    n_lvl = r_leaf_d;
                end
            end
            bpt_pkg::S_MRG: begin
                n_node = mem_ridx;
                n_lvlv = r_isleaf ? '0 : rd.level;
                tv_load = 1'b1;
                if (!r_isleaf && ccnt < CW'(MAX_KEYS)) begin
                    mem_we = 1'b1;
                    mem_waddr = mem_ridx;
                    mem_wdata = ins_row;
                end
            end
            bpt_pkg::S_WL: begin
                mem_we = 1'b1;
            end
            bpt_pkg::S_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_free[NB-1:0];
                mem_wdata = r_isleaf ? wr_leaf : wr_int;
                n_sep = r_isleaf ? r_tk[LEAF_L] : r_tk[MID];
                n_right = r_free[NB-1:0];
                n_free = r_free + FW'(1);
                n_isleaf = 1'b0;
                if (r_lvl != '0) n_lvl = r_lvl - DW'(1);
            end
            bpt_pkg::S_URD: begin
                mem_re = 1'b1;
                mem_raddr = r_pnode[r_lvl];
            end
            bpt_pkg::S_ROOT: begin
                mem_we = 1'b1;
                mem_waddr = r_free[NB-1:0];
                mem_wdata = root_row;
                n_root = r_free[NB-1:0];
                n_free = r_free + FW'(1);
            end
            bpt_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpt_pkg::S_IDLE;
            r_root   <= '0;
            r_free   <= FW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            r_free  <= n_free;
            if (r_state == bpt_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
            r_val <= SW'(val64[VALUE_BITS-1:0]);
        end
        r_d <= n_d;  r_leaf_d <= n_leaf_d;  r_k <= n_k;  r_need <= n_need;
        r_pos <= n_pos;  r_lvl <= n_lvl;  r_isleaf <= n_isleaf;  r_node <= n_node;
        r_lvlv <= n_lvlv;  r_sep <= n_sep;  r_right <= n_right;
        r_status <= n_status;  r_found <= n_found;
        if (tv_load) begin
            r_tk <= mg_tk;
            r_tv <= mg_tv;
        end
        if (path_we) begin
            r_pnode[r_d[DW-1:0]] <= mem_ridx;
            r_ppos[r_d[DW-1:0]]  <= route;
            r_pfull[r_d[DW-1:0]] <= (ccnt == CW'(MAX_KEYS));
        end
        if (r_state == bpt_pkg::S_DONE && out_free) begin
            r_ostatus <= r_status;
            r_ofound  <= r_found;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_found_value = r_ofound;
endmodule
`default_nettype wire

// ===== sv/bpt_checker.sv =====
// Port-level checker for the B+-tree key index, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module bpt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_found_value
);
    logic        in_acc;
    logic        out_stall;
    logic        out_err;
    logic [34:0] out_word;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_err   = o_out_valid && (o_status != bpt_pkg::ST_OK);
    assign out_word  = {o_status, o_found_value};

    `BPT_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_out_valid)
    `BPT_ASSERT(a_one_in_flight, in_acc |=> !o_in_ready)
    `BPT_ASSERT(a_status_legal, o_out_valid |-> (o_status <= bpt_pkg::ST_TOO_DEEP))
    `BPT_ASSERT(a_value_only_ok, out_err |-> (o_found_value == '0))
    `BPT_ASSERT(a_out_hold, out_stall |=> (o_out_valid && $stable(out_word)))
endmodule

bind bplus_tree_key_index bpt_checker u_bpt_checker (.*);
`default_nettype wire
